### design/frdr_pkg.sv
package frdr_pkg;

  localparam int NUM_WAVELENGTHS = 4;
  localparam int ETA_REGS        = 4;
  localparam int ETA_SEL_W       = $clog2(ETA_REGS);
  localparam int ETA_W           = 16;
  localparam int COS_W           = 16;
  localparam int WL_W            = 2;
  localparam int REFL_W          = 16;
  localparam int CFG_IDX_W       = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // register map: outer indices first, then inner indices
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_BASE = CFG_IDX_W'(ETA_REGS);

  localparam logic [ETA_W-1:0] ETA_OUTER_RST = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_INNER_RST = 16'd6144;

  localparam logic [30:0]       Q30_ONE    = 31'h4000_0000;
  localparam logic [16:0]       RATIO_ONE  = 17'h10000;
  localparam logic [34:0]       ROUND_HALF = 35'h10000;
  localparam logic [REFL_W-1:0] REFL_MAX   = 16'hFFFF;

  localparam int DIV1_STEPS = 31;
  localparam int SQRT_STEPS = 16;
  localparam int DIV2_STEPS = 17;

  typedef struct packed {
    logic [16:0]      ce;
    logic [ETA_W-1:0] e_in;
    logic [ETA_W-1:0] e_out;
  } frdr_item_t;

endpackage

### design/frdr_front.sv
module frdr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [frdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frdr_pkg::ETA_W-1:0]       cfg_data,
  input  logic signed [frdr_pkg::COS_W-1:0] cos_incident,
  input  logic [frdr_pkg::WL_W-1:0]        wavelength_index,
  output frdr_pkg::frdr_item_t             item
);

  logic [frdr_pkg::ETA_W-1:0] eta_outer_r [0:frdr_pkg::ETA_REGS-1];
  logic [frdr_pkg::ETA_W-1:0] eta_inner_r [0:frdr_pkg::ETA_REGS-1];
  logic [frdr_pkg::ETA_SEL_W-1:0] wl;
  logic [frdr_pkg::ETA_W-1:0] eo;
  logic [frdr_pkg::ETA_W-1:0] ei;
  logic entering;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < frdr_pkg::ETA_REGS; i++) begin
        eta_outer_r[i] <= frdr_pkg::ETA_OUTER_RST;
        eta_inner_r[i] <= frdr_pkg::ETA_INNER_RST;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index < frdr_pkg::CFG_INNER_BASE) begin
        eta_outer_r[cfg_index[frdr_pkg::ETA_SEL_W-1:0]] <= cfg_data;
      end else begin
        eta_inner_r[cfg_index[frdr_pkg::ETA_SEL_W-1:0]] <= cfg_data;
      end
    end
  end

  always_comb begin
    if ({1'b0, wavelength_index} >= (frdr_pkg::WL_W + 1)'(frdr_pkg::NUM_WAVELENGTHS)) begin
      wl = frdr_pkg::ETA_SEL_W'(frdr_pkg::NUM_WAVELENGTHS - 1);
    end else begin
      wl = frdr_pkg::ETA_SEL_W'(wavelength_index);
    end
  end

  assign eo       = eta_outer_r[wl];
  assign ei       = eta_inner_r[wl];
  assign entering = !cos_incident[frdr_pkg::COS_W-1] && (cos_incident != '0);

  always_comb begin
    // |c| needs 17 bits for -1.0
    if (cos_incident[frdr_pkg::COS_W-1]) begin
      item.ce = 17'(~{cos_incident[frdr_pkg::COS_W-1], cos_incident} + 17'd1);
    end else begin
      item.ce = {1'b0, cos_incident};
    end
    item.e_in  = entering ? eo : ei;
    item.e_out = entering ? ei : eo;
  end

endmodule

### design/frdr_fifo.sv
module frdr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  frdr_pkg::frdr_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output logic                 rd_valid,
  output frdr_pkg::frdr_item_t rd_item
);

  frdr_pkg::frdr_item_t mem_r [0:frdr_pkg::FIFO_DEPTH-1];
  logic [frdr_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [frdr_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [frdr_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic [frdr_pkg::FIFO_CNT_W-1:0] cnt_nxt;
  logic push_ok;
  logic pop_ok;

  assign full     = (cnt_r == frdr_pkg::FIFO_CNT_W'(frdr_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push_ok  = wr_en && !full;
  assign pop_ok   = rd_en && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### design/frdr_back.sv
module frdr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  frdr_pkg::frdr_item_t        item,
  output logic                        item_take,
  input  logic                        res_pop,
  output logic                        res_valid,
  output logic [frdr_pkg::REFL_W-1:0] res_refl,
  output logic                        res_tir
);

  localparam int D1 = frdr_pkg::DIV1_STEPS;
  localparam int SQ = frdr_pkg::SQRT_STEPS;
  localparam int D2 = frdr_pkg::DIV2_STEPS;

  logic en;
  logic out_v_r;
  logic [frdr_pkg::REFL_W-1:0] out_refl_r;
  logic out_tir_r;

  // whole pipeline advances unless a finished result is waiting
  assign en        = !out_v_r || res_pop;
  assign item_take = en;

  // squares of the indices and sin^2 of the incident angle
  logic a_v_r;
  frdr_pkg::frdr_item_t a_it_r;
  logic [31:0] a_ein2_r;
  logic [31:0] a_eout2_r;
  logic [30:0] a_sin2_r;
  logic [30:0] ce_sq;

  assign ce_sq = 31'(item.ce) * 31'(item.ce);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it_r    <= item;
      a_ein2_r  <= 32'(item.e_in) * 32'(item.e_in);
      a_eout2_r <= 32'(item.e_out) * 32'(item.e_out);
      a_sin2_r  <= frdr_pkg::Q30_ONE - ce_sq;
    end
  end

  logic b_v_r;
  frdr_pkg::frdr_item_t b_it_r;
  logic [61:0] b_lhs_r;
  logic [31:0] b_eout2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_it_r    <= a_it_r;
      b_lhs_r   <= 62'(a_ein2_r) * 62'(a_sin2_r);
      b_eout2_r <= a_eout2_r;
    end
  end

  // exit cos^2 = (eout^2 * 2^30 - lhs) / eout^2, one quotient bit per stage
  logic [61:0] rhs;
  logic [61:0] num;
  logic        tir_c;

  assign rhs   = {b_eout2_r, 30'b0};
  assign tir_c = (b_lhs_r >= rhs);
  assign num   = rhs - b_lhs_r;

  logic                 d1_v_r   [0:D1];
  frdr_pkg::frdr_item_t d1_it_r  [0:D1];
  logic                 d1_tir_r [0:D1];
  logic [31:0]          d1_d_r   [0:D1];
  logic [31:0]          d1_rem_r [0:D1];
  logic [30:0]          d1_nlo_r [0:D1];
  logic [30:0]          d1_q_r   [0:D1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r[0] <= 1'b0;
    end else if (en) begin
      d1_v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_it_r[0]  <= b_it_r;
      d1_tir_r[0] <= tir_c;
      d1_d_r[0]   <= b_eout2_r;
      d1_rem_r[0] <= {1'b0, num[61:31]};
      d1_nlo_r[0] <= num[30:0];
      d1_q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < D1; k++) begin : g_div1
    logic [32:0] t;
    logic        ge;

    assign t  = {d1_rem_r[k], d1_nlo_r[k][30]};
    assign ge = (t >= {1'b0, d1_d_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k+1] <= 1'b0;
      end else if (en) begin
        d1_v_r[k+1] <= d1_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_it_r[k+1]  <= d1_it_r[k];
        d1_tir_r[k+1] <= d1_tir_r[k];
        d1_d_r[k+1]   <= d1_d_r[k];
        d1_rem_r[k+1] <= ge ? 32'(t - {1'b0, d1_d_r[k]}) : t[31:0];
        d1_nlo_r[k+1] <= {d1_nlo_r[k][29:0], 1'b0};
        d1_q_r[k+1]   <= {d1_q_r[k][29:0], ge};
      end
    end
  end

  // integer square root, two radicand bits per stage
  logic                 sq_v_r    [0:SQ];
  frdr_pkg::frdr_item_t sq_it_r   [0:SQ];
  logic                 sq_tir_r  [0:SQ];
  logic [31:0]          sq_rad_r  [0:SQ];
  logic [17:0]          sq_rem_r  [0:SQ];
  logic [15:0]          sq_root_r [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= d1_v_r[D1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_it_r[0]   <= d1_it_r[D1];
      sq_tir_r[0]  <= d1_tir_r[D1];
      sq_rad_r[0]  <= {1'b0, d1_q_r[D1]};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [19:0] r2;
    logic [19:0] trial;
    logic        ge;

    assign r2    = {sq_rem_r[k], sq_rad_r[k][31:30]};
    assign trial = {2'b0, sq_root_r[k], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_it_r[k+1]   <= sq_it_r[k];
        sq_tir_r[k+1]  <= sq_tir_r[k];
        sq_rad_r[k+1]  <= {sq_rad_r[k][29:0], 2'b00};
        sq_rem_r[k+1]  <= ge ? 18'(r2 - trial) : r2[17:0];
        sq_root_r[k+1] <= {sq_root_r[k][14:0], ge};
      end
    end
  end

  // lane 0: parallel terms (eout*ce, ein*cx); lane 1: perpendicular (ein*ce, eout*cx)
  logic        m_v_r;
  logic        m_tir_r;
  logic [32:0] m_hi_r [0:1];
  logic [32:0] m_lo_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= sq_v_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tir_r   <= sq_tir_r[SQ];
      m_hi_r[0] <= 33'(sq_it_r[SQ].e_out) * 33'(sq_it_r[SQ].ce);
      m_lo_r[0] <= 33'(sq_it_r[SQ].e_in) * 33'(sq_root_r[SQ]);
      m_hi_r[1] <= 33'(sq_it_r[SQ].e_in) * 33'(sq_it_r[SQ].ce);
      m_lo_r[1] <= 33'(sq_it_r[SQ].e_out) * 33'(sq_root_r[SQ]);
    end
  end

  // |x-y| * 2^16 / (x+y), one quotient bit per stage, both lanes side by side
  logic        dv_v_r   [0:D2];
  logic        dv_tir_r [0:D2];
  logic        dv_z_r   [0:1][0:D2];
  logic [33:0] dv_s_r   [0:1][0:D2];
  logic [33:0] dv_rem_r [0:1][0:D2];
  logic [16:0] dv_lo_r  [0:1][0:D2];
  logic [16:0] dv_q_r   [0:1][0:D2];
  logic [16:0] ratio    [0:1];
  logic [33:0] sq_r     [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_tir_r[0] <= m_tir_r;
    end
  end

  for (genvar k = 0; k < D2; k++) begin : g_div2_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_tir_r[k+1] <= dv_tir_r[k];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [33:0] sum;
    logic [32:0] df;

    assign sum = 34'(m_hi_r[l]) + 34'(m_lo_r[l]);
    assign df  = (m_hi_r[l] >= m_lo_r[l]) ? (m_hi_r[l] - m_lo_r[l])
                                          : (m_lo_r[l] - m_hi_r[l]);

    always_ff @(posedge clk) begin
      if (en) begin
        dv_z_r[l][0]   <= (sum == '0);
        dv_s_r[l][0]   <= sum;
        dv_rem_r[l][0] <= {2'b00, df[32:1]};
        dv_lo_r[l][0]  <= {df[0], 16'b0};
        dv_q_r[l][0]   <= '0;
      end
    end

    for (genvar k = 0; k < D2; k++) begin : g_step
      logic [34:0] t;
      logic        ge;

      assign t  = {dv_rem_r[l][k], dv_lo_r[l][k][16]};
      assign ge = (t >= {1'b0, dv_s_r[l][k]});

      always_ff @(posedge clk) begin
        if (en) begin
          dv_z_r[l][k+1]   <= dv_z_r[l][k];
          dv_s_r[l][k+1]   <= dv_s_r[l][k];
          dv_rem_r[l][k+1] <= ge ? 34'(t - {1'b0, dv_s_r[l][k]}) : t[33:0];
          dv_lo_r[l][k+1]  <= {dv_lo_r[l][k][15:0], 1'b0};
          dv_q_r[l][k+1]   <= {dv_q_r[l][k][15:0], ge};
        end
      end
    end

    // zero sum: ratio counts as 1.0
    assign ratio[l] = dv_z_r[l][D2] ? frdr_pkg::RATIO_ONE : dv_q_r[l][D2];

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[l] <= 34'(ratio[l]) * 34'(ratio[l]);
      end
    end
  end

  logic q_v_r;
  logic q_tir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= dv_v_r[D2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_tir_r <= dv_tir_r[D2];
    end
  end

  logic [34:0] acc;
  logic [17:0] avg;

  assign acc = 35'(sq_r[0]) + 35'(sq_r[1]) + frdr_pkg::ROUND_HALF;
  assign avg = acc[34:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tir_r <= q_tir_r;
      if (q_tir_r || (avg > 18'(frdr_pkg::REFL_MAX))) begin
        out_refl_r <= frdr_pkg::REFL_MAX;
      end else begin
        out_refl_r <= avg[15:0];
      end
    end
  end

  assign res_valid = out_v_r;
  assign res_refl  = out_refl_r;
  assign res_tir   = out_tir_r;

endmodule

### design/fresnel_dielectric_reflectance_core.sv
// Unpolarized Fresnel reflectance of a dielectric boundary, one wavelength per query.
// Input side is a queue: present in_cos_incident (Q1.15) and in_wavelength_index with
// push; the transfer happens on a rising edge with push high and full low.
// Result side is a queue: while empty is low, out_reflectance (Q0.16) and
// out_total_internal carry the oldest result; pop high with empty low transfers it.
// Configuration: cfg_wr_en with cfg_index 0..3 writes the outer index, 4..7 the inner
// index (Q4.12) per wavelength; writes take effect on the next edge. Write only while
// idle; the block itself does not enforce this. Results pass through a bit-serial
// pipeline (31-stage exit cos^2 divider, 16-stage square root, 17-stage ratio dividers).
// Throughput: one item per cycle, sustained, while the result side pops.
// Reset (rst_n low, synchronous) empties the queues and the pipeline and loads the
// index registers with 1.0 (outer) and 1.5 (inner).
// When the receiver stalls, the pipeline freezes; a 4-entry queue behind the input
// absorbs pushes until full rises, and nothing is dropped.
module fresnel_dielectric_reflectance_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [frdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frdr_pkg::ETA_W-1:0]        cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic signed [frdr_pkg::COS_W-1:0] in_cos_incident,
  input  logic [frdr_pkg::WL_W-1:0]         in_wavelength_index,
  output logic                              empty,
  input  logic                              pop,
  output logic [frdr_pkg::REFL_W-1:0]       out_reflectance,
  output logic                              out_total_internal
);

  frdr_pkg::frdr_item_t front_item;
  frdr_pkg::frdr_item_t head_item;
  logic head_valid;
  logic head_take;
  logic res_valid;

  frdr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cos_incident     (in_cos_incident),
    .wavelength_index (in_wavelength_index),
    .item             (front_item)
  );

  frdr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (head_take),
    .rd_valid (head_valid),
    .rd_item  (head_item)
  );

  frdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (head_valid),
    .item       (head_item),
    .item_take  (head_take),
    .res_pop    (pop),
    .res_valid  (res_valid),
    .res_refl   (out_reflectance),
    .res_tir    (out_total_internal)
  );

  assign empty = !res_valid;

  a_tir_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_total_internal) |-> (out_reflectance == frdr_pkg::REFL_MAX))
    else $error("total internal reflection without full reflectance");

  a_full_needs_push : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a push");

  a_reset_clears : assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule
